// ----- rtl/mlsc_pkg.sv -----
// ----------------------------------------------------------------------------
// mlsc_pkg
// Shared types, constants and the operation program of the light-speed block.
// ----------------------------------------------------------------------------
package mlsc_pkg;

	localparam int DATA_WIDTH    = 48;
	localparam int FRAC_BITS_DEF = 24;
	localparam int NSLOT         = 32;
	localparam int SLOT_W        = 5;
	localparam int PC_W          = 6;

	localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic [DATA_WIDTH-1:0] radius_cyl;
		logic [DATA_WIDTH-1:0] height_z;
		logic [DATA_WIDTH-1:0] conformal_psi4;
		logic [DATA_WIDTH-1:0] metric_a;
		logic [DATA_WIDTH-1:0] metric_b;
		logic [DATA_WIDTH-1:0] metric_h;
		logic [DATA_WIDTH-1:0] metric_c;
		logic [DATA_WIDTH-1:0] lapse;
		logic                  last_point;
	} point_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] sph_rr;
		logic [DATA_WIDTH-1:0] sph_thth;
		logic [DATA_WIDTH-1:0] sph_phph;
		logic [DATA_WIDTH-1:0] sph_rth;
		logic [DATA_WIDTH-1:0] inv_rr;
		logic [DATA_WIDTH-1:0] inv_thth;
		logic [DATA_WIDTH-1:0] inv_phph;
		logic [DATA_WIDTH-1:0] inv_rth;
		logic [DATA_WIDTH-1:0] speed_r;
		logic [DATA_WIDTH-1:0] speed_theta;
		logic [DATA_WIDTH-1:0] speed_phi;
		logic [2:0]            cfl_code;
	} metric_t;

	typedef enum logic [2:0] {
		OP_ADD, OP_SUB, OP_ABS, OP_NEG, OP_MUL, OP_DIV, OP_SQRT, OP_CFL
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_READ, ST_ISSUE, ST_WAIT, ST_DONE
	} state_t;

	localparam logic [2:0] CFL_NONE = 3'd0;
	localparam logic [2:0] CFL_1    = 3'd1;
	localparam logic [2:0] CFL_2    = 3'd2;
	localparam logic [2:0] CFL_3    = 3'd3;
	localparam logic [2:0] CFL_4    = 3'd4;
	localparam logic [2:0] CFL_VIOL = 3'd5;

	localparam logic [SLOT_W-1:0] SL_R     = 5'd0;
	localparam logic [SLOT_W-1:0] SL_Z     = 5'd1;
	localparam logic [SLOT_W-1:0] SL_PSI   = 5'd2;
	localparam logic [SLOT_W-1:0] SL_A     = 5'd3;
	localparam logic [SLOT_W-1:0] SL_B     = 5'd4;
	localparam logic [SLOT_W-1:0] SL_H     = 5'd5;
	localparam logic [SLOT_W-1:0] SL_C     = 5'd6;
	localparam logic [SLOT_W-1:0] SL_ALPHA = 5'd7;
	localparam logic [SLOT_W-1:0] SL_ONE   = 5'd8;
	localparam logic [SLOT_W-1:0] SL_K     = 5'd9;

	localparam logic [3:0] OUT_RR   = 4'd0;
	localparam logic [3:0] OUT_TT   = 4'd1;
	localparam logic [3:0] OUT_PP   = 4'd2;
	localparam logic [3:0] OUT_RT   = 4'd3;
	localparam logic [3:0] OUT_IRR  = 4'd4;
	localparam logic [3:0] OUT_ITT  = 4'd5;
	localparam logic [3:0] OUT_IPP  = 4'd6;
	localparam logic [3:0] OUT_IRT  = 4'd7;
	localparam logic [3:0] OUT_SR   = 4'd8;
	localparam logic [3:0] OUT_ST   = 4'd9;
	localparam logic [3:0] OUT_SP   = 4'd10;
	localparam logic [3:0] OUT_NONE = 4'd15;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] dst;
		logic [SLOT_W-1:0] sa;
		logic [SLOT_W-1:0] sb;
		logic [3:0]        oidx;
	} instr_t;

	localparam int PROG_LEN = 53;

	localparam instr_t PROG [PROG_LEN] = '{
		'{OP_MUL,  5'd10, SL_PSI, SL_A,  OUT_NONE},
		'{OP_MUL,  5'd11, SL_PSI, SL_B,  OUT_NONE},
		'{OP_MUL,  5'd12, SL_PSI, SL_H,  OUT_NONE},
		'{OP_MUL,  5'd13, SL_PSI, SL_C,  OUT_NONE},
		'{OP_MUL,  5'd14, SL_R,   SL_R,  OUT_NONE},
		'{OP_MUL,  5'd15, SL_Z,   SL_Z,  OUT_NONE},
		'{OP_ADD,  5'd15, 5'd14,  5'd15, OUT_NONE},
		'{OP_SQRT, 5'd16, 5'd15,  5'd15, OUT_NONE},
		'{OP_DIV,  5'd17, SL_Z,   5'd16, OUT_NONE},
		'{OP_DIV,  5'd18, SL_R,   5'd16, OUT_NONE},
		'{OP_MUL,  5'd19, 5'd17,  5'd17, OUT_NONE},
		'{OP_MUL,  5'd20, 5'd18,  5'd18, OUT_NONE},
		'{OP_MUL,  5'd21, 5'd17,  5'd18, OUT_NONE},
		'{OP_ADD,  5'd22, 5'd21,  5'd21, OUT_NONE},
		'{OP_SUB,  5'd23, 5'd19,  5'd20, OUT_NONE},
		'{OP_MUL,  5'd24, 5'd13,  SL_R,  OUT_NONE},
		'{OP_MUL,  5'd25, 5'd24,  5'd22, OUT_NONE},
		'{OP_MUL,  5'd26, 5'd11,  5'd19, OUT_NONE},
		'{OP_MUL,  5'd27, 5'd10,  5'd20, OUT_NONE},
		'{OP_ADD,  5'd26, 5'd26,  5'd27, OUT_NONE},
		'{OP_ADD,  5'd26, 5'd26,  5'd25, OUT_RR},
		'{OP_MUL,  5'd27, 5'd10,  5'd19, OUT_NONE},
		'{OP_SUB,  5'd27, 5'd27,  5'd25, OUT_NONE},
		'{OP_MUL,  5'd28, 5'd11,  5'd20, OUT_NONE},
		'{OP_ADD,  5'd27, 5'd27,  5'd28, OUT_NONE},
		'{OP_MUL,  5'd27, 5'd27,  5'd15, OUT_TT},
		'{OP_MUL,  5'd28, 5'd12,  5'd14, OUT_PP},
		'{OP_MUL,  5'd29, 5'd24,  5'd23, OUT_NONE},
		'{OP_SUB,  5'd30, 5'd10,  5'd11, OUT_NONE},
		'{OP_MUL,  5'd30, 5'd30,  5'd21, OUT_NONE},
		'{OP_ADD,  5'd29, 5'd29,  5'd30, OUT_NONE},
		'{OP_MUL,  5'd29, 5'd29,  5'd16, OUT_RT},
		'{OP_MUL,  5'd0,  5'd26,  5'd27, OUT_NONE},
		'{OP_MUL,  5'd1,  5'd29,  5'd29, OUT_NONE},
		'{OP_SUB,  5'd0,  5'd0,   5'd1,  OUT_NONE},
		'{OP_ABS,  5'd2,  5'd26,  5'd26, OUT_NONE},
		'{OP_SQRT, 5'd2,  5'd2,   5'd2,  OUT_NONE},
		'{OP_ABS,  5'd3,  5'd27,  5'd27, OUT_NONE},
		'{OP_SQRT, 5'd3,  5'd3,   5'd3,  OUT_NONE},
		'{OP_ABS,  5'd4,  5'd28,  5'd28, OUT_NONE},
		'{OP_SQRT, 5'd4,  5'd4,   5'd4,  OUT_NONE},
		'{OP_MUL,  5'd5,  SL_K,   5'd2,  OUT_NONE},
		'{OP_ABS,  5'd6,  SL_ALPHA, SL_ALPHA, OUT_NONE},
		'{OP_DIV,  5'd5,  5'd5,   5'd6,  OUT_NONE},
		'{OP_CFL,  5'd5,  5'd5,   5'd5,  OUT_NONE},
		'{OP_DIV,  5'd10, 5'd27,  5'd0,  OUT_IRR},
		'{OP_DIV,  5'd11, 5'd26,  5'd0,  OUT_ITT},
		'{OP_DIV,  5'd12, SL_ONE, 5'd28, OUT_IPP},
		'{OP_NEG,  5'd13, 5'd29,  5'd29, OUT_NONE},
		'{OP_DIV,  5'd13, 5'd13,  5'd0,  OUT_IRT},
		'{OP_DIV,  5'd14, SL_ALPHA, 5'd2, OUT_SR},
		'{OP_DIV,  5'd15, SL_ALPHA, 5'd3, OUT_ST},
		'{OP_DIV,  5'd16, SL_ALPHA, 5'd4, OUT_SP}
	};

	function automatic logic [63:0] cfl_scale(input int f);
		logic [63:0] p;
		logic [63:0] res;
		logic [63:0] t;
		p   = '0;
		res = '0;
		for (int k = 0; k < f; k++) begin
			p[2*k] = 1'b1;
		end
		for (int i = 31; i >= 0; i--) begin
			t = res | (64'd1 << i);
			if (t * t <= p) begin
				res = t;
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/metric_light_speed_courant.sv -----
// ----------------------------------------------------------------------------
// metric_light_speed_courant
// Spherical metric, inverse, light speeds and Courant code for one grid point.
// ----------------------------------------------------------------------------
// Usage:
// A request on the point channel (point_valid/point_stall) carries one grid
// point in signed Q fixed point. The block loads it into a 32-entry operand
// memory and runs a fixed 53-step program through one shared unit.
// One metric result leaves on the metric channel (metric_valid/metric_stall)
// for every request.
// Each point loads ten operands and then runs 23 multiplies, 10 divides,
// four square roots, 15 one-step operations and the Courant step, all
// through the shared unit; a new point is not accepted before the last
// one is finished. point_stall is high from acceptance until the result
// moves into the output register. The output register holds a result
// while metric_stall is high; the next point is accepted as soon as the
// finished result has moved there. Reset empties both channels and sets
// the Courant minimum to the largest positive value; the last point of a
// sweep reports the code and resets it.
// ----------------------------------------------------------------------------
module metric_light_speed_courant #(
	parameter int FRAC_BITS = mlsc_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              point_valid,
	output logic              point_stall,
	input  mlsc_pkg::point_t  point,
	output logic              metric_valid,
	input  logic              metric_stall,
	output mlsc_pkg::metric_t metric
);
	import mlsc_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam logic [W-1:0] ONE    = W'(1) << FRAC_BITS;
	localparam logic [W-1:0] KSCALE = W'(cfl_scale(FRAC_BITS));

	state_t            state_q;
	state_t            state_d;
	point_t            in_q;
	metric_t           res_q;
	metric_t           out_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] ld_cnt_q;
	logic [PC_W-1:0]   pc_q;
	logic [W-1:0]      min_q;
	logic [W-1:0]      rf_mem [NSLOT];
	logic [W-1:0]      rda_q;
	logic [W-1:0]      rdb_q;

	instr_t            ins;
	logic              we;
	logic [SLOT_W-1:0] wa;
	logic [W-1:0]      wd;
	logic [W-1:0]      ld_val;
	alu_cmd_t          cmd;
	logic              alu_done;
	logic [W-1:0]      alu_res;
	logic              last_ins;
	logic              out_free;
	logic [W-1:0]      m_new;
	logic [2:0]        code;

	assign ins      = PROG[pc_q];
	assign last_ins = (pc_q == PC_W'(PROG_LEN - 1));
	assign out_free = !out_valid_q || !metric_stall;

	mlsc_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.a      (rda_q),
		.b      (rdb_q),
		.done   (alu_done),
		.result (alu_res)
	);

	always_comb begin
		unique case (ld_cnt_q)
			SL_R:     ld_val = in_q.radius_cyl;
			SL_Z:     ld_val = in_q.height_z;
			SL_PSI:   ld_val = in_q.conformal_psi4;
			SL_A:     ld_val = in_q.metric_a;
			SL_B:     ld_val = in_q.metric_b;
			SL_H:     ld_val = in_q.metric_h;
			SL_C:     ld_val = in_q.metric_c;
			SL_ALPHA: ld_val = in_q.lapse;
			SL_ONE:   ld_val = ONE;
			default:  ld_val = KSCALE;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (point_valid) state_d = ST_LOAD;
			ST_LOAD:  if (ld_cnt_q == SL_K) state_d = ST_READ;
			ST_READ:  state_d = ST_ISSUE;
			ST_ISSUE: begin
				if (ins.op != OP_CFL) state_d = ST_WAIT;
				else state_d = last_ins ? ST_DONE : ST_READ;
			end
			ST_WAIT:  if (alu_done) state_d = last_ins ? ST_DONE : ST_READ;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we        = 1'b0;
		wa        = ins.dst;
		wd        = alu_res;
		cmd.start = 1'b0;
		cmd.op    = ins.op;
		unique case (state_q)
			ST_LOAD: begin
				we = 1'b1;
				wa = ld_cnt_q;
				wd = ld_val;
			end
			ST_ISSUE: cmd.start = (ins.op != OP_CFL);
			ST_WAIT:  we = alu_done;
			default: ;
		endcase
	end

	always_comb begin
		m_new = ($signed(rda_q) < $signed(min_q)) ? rda_q : min_q;
		if ($signed(m_new) >= $signed(ONE)) code = CFL_1;
		else if ($signed(m_new) >= $signed(ONE >> 1)) code = CFL_2;
		else if ($signed(m_new) >= $signed(ONE >> 2)) code = CFL_3;
		else if ($signed(m_new) >= $signed(ONE >> 3)) code = CFL_4;
		else code = CFL_VIOL;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			rf_mem[wa] <= wd;
		end
		rda_q <= rf_mem[ins.sa];
		rdb_q <= rf_mem[ins.sb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ld_cnt_q    <= '0;
			pc_q        <= '0;
			min_q       <= DMAX;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				ld_cnt_q <= '0;
				pc_q     <= '0;
			end
			if (state_q == ST_LOAD) begin
				ld_cnt_q <= ld_cnt_q + 1'b1;
			end
			if ((state_q == ST_ISSUE && ins.op == OP_CFL) || (state_q == ST_WAIT && alu_done)) begin
				pc_q <= pc_q + 1'b1;
			end
			if (state_q == ST_ISSUE && ins.op == OP_CFL) begin
				min_q <= in_q.last_point ? DMAX : m_new;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!metric_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && point_valid) begin
			in_q <= point;
		end
		if (state_q == ST_ISSUE && ins.op == OP_CFL) begin
			res_q.cfl_code <= in_q.last_point ? code : CFL_NONE;
		end
		if (state_q == ST_WAIT && alu_done) begin
			unique case (ins.oidx)
				OUT_RR:  res_q.sph_rr      <= alu_res;
				OUT_TT:  res_q.sph_thth    <= alu_res;
				OUT_PP:  res_q.sph_phph    <= alu_res;
				OUT_RT:  res_q.sph_rth     <= alu_res;
				OUT_IRR: res_q.inv_rr      <= alu_res;
				OUT_ITT: res_q.inv_thth    <= alu_res;
				OUT_IPP: res_q.inv_phph    <= alu_res;
				OUT_IRT: res_q.inv_rth     <= alu_res;
				OUT_SR:  res_q.speed_r     <= alu_res;
				OUT_ST:  res_q.speed_theta <= alu_res;
				OUT_SP:  res_q.speed_phi   <= alu_res;
				default: ;
			endcase
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign point_stall  = (state_q != ST_IDLE);
	assign metric_valid = out_valid_q;
	assign metric       = out_q;

endmodule

// ----- rtl/mlsc_alu.sv -----
// ----------------------------------------------------------------------------
// mlsc_alu
// Shared saturating fixed-point unit: add, sub, abs, neg as single steps;
// multiply, divide and square root one bit per cycle.
// ----------------------------------------------------------------------------
module mlsc_alu #(
	parameter int FRAC_BITS = mlsc_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mlsc_pkg::alu_cmd_t              cmd,
	input  logic [mlsc_pkg::DATA_WIDTH-1:0] a,
	input  logic [mlsc_pkg::DATA_WIDTH-1:0] b,
	output logic                            done,
	output logic [mlsc_pkg::DATA_WIDTH-1:0] result
);
	import mlsc_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int NW = W + FRAC_BITS;
	localparam int XW = NW + (NW % 2);
	localparam int CW = $clog2(NW + 1);
	localparam int MW = 2 * W;

	op_t           op_q;
	logic          busy_q;
	logic          done_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  ma_q;
	logic [XW-1:0] mb_q;
	logic [MW-1:0] acc_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  res_q;

	logic [W:0]    t_div;
	logic [W:0]    t_sqrt;
	logic [W:0]    trial;
	logic          ge_div;
	logic          ge_sqrt;
	logic [MW-1:0] mul_next;
	logic [MW-1:0] mul_shift;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [W-1:0] sat(input logic [MW-1:0] m, input logic neg);
		logic [MW-1:0] lim;
		logic [W-1:0]  v;
		lim = MW'(DMAX) + MW'(neg);
		v   = (m > lim) ? lim[W-1:0] : m[W-1:0];
		return neg ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [W-1:0] clamp(input logic [W:0] s);
		if (s[W] != s[W-1]) begin
			return s[W] ? DMIN : DMAX;
		end
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] sneg(input logic [W-1:0] v);
		return (v == DMIN) ? DMAX : (~v + 1'b1);
	endfunction

	always_comb begin
		t_div     = {rem_q[W-1:0], mb_q[XW-1]};
		ge_div    = t_div >= {1'b0, ma_q};
		t_sqrt    = {rem_q[W-2:0], mb_q[XW-1 -: 2]};
		trial     = {acc_q[W-2:0], 2'b01};
		ge_sqrt   = t_sqrt >= trial;
		mul_shift = acc_q >> FRAC_BITS;
		mul_next  = {acc_q[MW-2:0], 1'b0} + (mb_q[XW-1] ? MW'(ma_q) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_ADD;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				op_q <= cmd.op;
				case (cmd.op)
					OP_MUL: begin
						busy_q <= 1'b1;
						cnt_q  <= CW'(W);
					end
					OP_DIV: begin
						busy_q <= (b != '0);
						done_q <= (b == '0);
						cnt_q  <= CW'(NW);
					end
					OP_SQRT: begin
						busy_q <= 1'b1;
						cnt_q  <= CW'(XW / 2);
					end
					default: done_q <= 1'b1;
				endcase
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
			rem_q <= '0;
			case (cmd.op)
				OP_ADD:  res_q <= clamp({a[W-1], a} + {b[W-1], b});
				OP_SUB:  res_q <= clamp({a[W-1], a} - {b[W-1], b});
				OP_NEG:  res_q <= sneg(a);
				OP_ABS:  res_q <= a[W-1] ? sneg(a) : a;
				OP_MUL: begin
					ma_q  <= mag(a);
					mb_q  <= {mag(b), {(XW-W){1'b0}}};
					neg_q <= a[W-1] ^ b[W-1];
				end
				OP_DIV: begin
					ma_q  <= mag(b);
					mb_q  <= {mag(a), {(XW-W){1'b0}}};
					neg_q <= a[W-1] ^ b[W-1];
					res_q <= (a == '0) ? '0 : (a[W-1] ? DMIN : DMAX);
				end
				OP_SQRT: begin
					mb_q  <= a[W-1] ? '0 : (XW'(a) << FRAC_BITS);
					neg_q <= 1'b0;
				end
				default: res_q <= a;
			endcase
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				case (op_q)
					OP_MUL: begin
						acc_q <= mul_next;
						mb_q  <= mb_q << 1;
					end
					OP_DIV: begin
						rem_q <= ge_div ? (t_div - {1'b0, ma_q}) : t_div;
						acc_q <= {acc_q[MW-2:0], ge_div};
						mb_q  <= mb_q << 1;
					end
					default: begin
						rem_q <= ge_sqrt ? (t_sqrt - trial) : t_sqrt;
						acc_q <= {acc_q[MW-2:0], ge_sqrt};
						mb_q  <= mb_q << 2;
					end
				endcase
			end else begin
				res_q <= sat((op_q == OP_MUL) ? mul_shift : acc_q, neg_q);
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- rtl/mlsc_chk.sv -----
// ----------------------------------------------------------------------------
// mlsc_chk
// Port-level checks for the light-speed block, bound to the top level.
// ----------------------------------------------------------------------------
module mlsc_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              point_valid,
	input logic              point_stall,
	input mlsc_pkg::point_t  point,
	input logic              metric_valid,
	input logic              metric_stall,
	input mlsc_pkg::metric_t metric
);
	import mlsc_pkg::*;

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall |=> point_stall)
		else $error("request accepted while idle did not make the block busy");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		metric_valid && metric_stall |=> metric_valid && $stable(metric))
		else $error("stalled result changed or dropped");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(metric_valid) |-> $past(point_stall))
		else $error("result appeared without work in progress");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		metric_valid |-> metric.cfl_code <= CFL_VIOL)
		else $error("courant code out of range");

endmodule

bind metric_light_speed_courant mlsc_chk u_mlsc_chk (.*);

// ----- tb/metric_light_speed_courant_tb.sv -----
// ----------------------------------------------------------------------------
// metric_light_speed_courant_tb
// Self-checking bench for the light-speed and Courant unit: grid points are
// streamed in bursts, every result is checked field by field against an
// in-bench fixed-point predictor that tracks the running Courant minimum.
// ----------------------------------------------------------------------------
module metric_light_speed_courant_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mlsc_pkg::*;

	localparam longint QMAX     = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
	localparam longint QMIN     = -QMAX - 1;
	localparam int     FB       = FRAC_BITS_DEF;
	localparam longint QONE     = 64'sd1 <<< FB;
	localparam int     N_RANDOM = 1630;
	localparam int     WD_LIMIT = 40000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    point_valid = 1'b0;
	logic    point_stall;
	point_t  point = '0;
	logic    metric_valid;
	logic    metric_stall = 1'b0;
	metric_t metric;

	metric_light_speed_courant u_dut (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.metric_valid(metric_valid), .metric_stall(metric_stall), .metric(metric)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	point_t  pending[$];
	metric_t expected_metrics[$];
	longint  courant_floor;
	longint  k_scale;
	int      n_total, n_sent, n_recv, n_last, n_errors, drain_at;
	int      code_seen[8];
	bit      req_taken;
	bit      drained;
	int      burst_left, gap_left, idle_cycles, stall_phase, stall_mode;

	function automatic longint clampq(longint v);
		return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
	endfunction

	function automatic logic [127:0] magn(longint v);
		return 128'(v < 0 ? -v : v);
	endfunction

	function automatic longint from_mag(logic [127:0] m, bit neg);
		logic [127:0] lim;
		lim = 128'(QMAX) + 128'(neg);
		if (m > lim) m = lim;
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic longint qneg(longint v);
		return v <= QMIN ? QMAX : -v;
	endfunction

	function automatic longint qabs(longint v);
		return v < 0 ? qneg(v) : v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		logic [127:0] p;
		p = magn(a) * magn(b);
		return from_mag(p >> FB, (a < 0) != (b < 0));
	endfunction

	function automatic longint qdiv(longint n, longint d);
		logic [127:0] q;
		if (d == 0) return n > 0 ? QMAX : (n < 0 ? QMIN : 0);
		q = (magn(n) << FB) / magn(d);
		return from_mag(q, (n < 0) != (d < 0));
	endfunction

	function automatic logic [127:0] isqrt(logic [127:0] x);
		logic [127:0] res;
		logic [127:0] t;
		res = '0;
		for (int i = 63; i >= 0; i--) begin
			t = res | (128'd1 << i);
			if (t * t <= x) res = t;
		end
		return res;
	endfunction

	function automatic longint qsqrt(longint v);
		return from_mag(isqrt(v > 0 ? (magn(v) << FB) : 128'd0), 1'b0);
	endfunction

	function automatic longint sx(logic [DATA_WIDTH-1:0] f);
		return longint'($signed(f));
	endfunction

	function automatic metric_t predict_metric(point_t p);
		longint r, z, psi, pa, pb, ph, pc, alpha, r2, s2, s, cs, sn, cc, ss, x;
		longint dbl, dif, q, w, rr, tt, pp, rt, det, srr, stt, spp, cand;
		metric_t m;
		r = sx(p.radius_cyl); z = sx(p.height_z); psi = sx(p.conformal_psi4);
		pa = qmul(psi, sx(p.metric_a)); pb = qmul(psi, sx(p.metric_b));
		ph = qmul(psi, sx(p.metric_h)); pc = qmul(psi, sx(p.metric_c));
		alpha = sx(p.lapse);
		r2 = qmul(r, r); s2 = clampq(r2 + qmul(z, z)); s = qsqrt(s2);
		cs = qdiv(z, s); sn = qdiv(r, s);
		cc = qmul(cs, cs); ss = qmul(sn, sn); x = qmul(cs, sn);
		dbl = clampq(x + x); dif = clampq(cc - ss);
		q = qmul(pc, r); w = qmul(q, dbl);
		rr = clampq(clampq(qmul(pb, cc) + qmul(pa, ss)) + w);
		tt = qmul(clampq(clampq(qmul(pa, cc) - w) + qmul(pb, ss)), s2);
		pp = qmul(ph, r2);
		rt = qmul(clampq(qmul(q, dif) + qmul(clampq(pa - pb), x)), s);
		det = clampq(qmul(rr, tt) - qmul(rt, rt));
		srr = qsqrt(qabs(rr)); stt = qsqrt(qabs(tt)); spp = qsqrt(qabs(pp));
		cand = qdiv(qmul(k_scale, srr), qabs(alpha));
		m.sph_rr = rr[DATA_WIDTH-1:0];
		m.sph_thth = tt[DATA_WIDTH-1:0];
		m.sph_phph = pp[DATA_WIDTH-1:0];
		m.sph_rth = rt[DATA_WIDTH-1:0];
		m.inv_rr = 48'(qdiv(tt, det));
		m.inv_thth = 48'(qdiv(rr, det));
		m.inv_phph = 48'(qdiv(QONE, pp));
		m.inv_rth = 48'(qdiv(qneg(rt), det));
		m.speed_r = 48'(qdiv(alpha, srr));
		m.speed_theta = 48'(qdiv(alpha, stt));
		m.speed_phi = 48'(qdiv(alpha, spp));
		m.cfl_code = CFL_NONE;
		if (cand < courant_floor) courant_floor = cand;
		if (p.last_point) begin
			if (courant_floor >= QONE) m.cfl_code = CFL_1;
			else if (courant_floor >= (QONE >>> 1)) m.cfl_code = CFL_2;
			else if (courant_floor >= (QONE >>> 2)) m.cfl_code = CFL_3;
			else if (courant_floor >= (QONE >>> 3)) m.cfl_code = CFL_4;
			else m.cfl_code = CFL_VIOL;
			courant_floor = QMAX;
		end
		return m;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] rnd_span(int unsigned span, bit pos);
		longint v;
		v = longint'($urandom_range(span, 0));
		if (!pos && $urandom_range(1, 0)) v = -v;
		return v[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [DATA_WIDTH-1:0] rnd_wild();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(5, 0))
			0: return DMAX;
			1: return DMIN;
			2: return '0;
			3: return v[DATA_WIDTH-1:0] >> $urandom_range(40, 0);
			default: return v[DATA_WIDTH-1:0];
		endcase
	endfunction

	function automatic point_t make_point(bit wild, bit last);
		point_t p;
		p.radius_cyl = rnd_span(32'h0800_0000, 1'b0);
		p.height_z = rnd_span(32'h0800_0000, 1'b0);
		p.conformal_psi4 = 48'(QONE) + rnd_span(32'h0040_0000, 1'b0);
		p.metric_a = 48'(QONE) + rnd_span(32'h0040_0000, 1'b0);
		p.metric_b = 48'(QONE) + rnd_span(32'h0040_0000, 1'b0);
		p.metric_h = 48'(QONE) + rnd_span(32'h0040_0000, 1'b0);
		p.metric_c = rnd_span(32'h0020_0000, 1'b0);
		p.lapse = rnd_span(32'h0600_0000, $urandom_range(3, 0) != 0);
		if (wild) begin
			if ($urandom_range(1, 0)) p.radius_cyl = rnd_wild();
			if ($urandom_range(1, 0)) p.height_z = rnd_wild();
			if ($urandom_range(1, 0)) p.conformal_psi4 = rnd_wild();
			if ($urandom_range(1, 0)) p.metric_a = rnd_wild();
			if ($urandom_range(1, 0)) p.metric_b = rnd_wild();
			if ($urandom_range(1, 0)) p.metric_h = rnd_wild();
			if ($urandom_range(1, 0)) p.metric_c = rnd_wild();
			if ($urandom_range(1, 0)) p.lapse = rnd_wild();
		end
		p.last_point = last;
		return p;
	endfunction

	task automatic check_field(string name, logic [DATA_WIDTH-1:0] exp_v,
			logic [DATA_WIDTH-1:0] act_v);
		if (exp_v !== act_v) begin
			n_errors++;
			if (n_errors <= 10)
				$display("mismatch result %0d %s: expected %h got %h", n_recv, name, exp_v,
					act_v);
		end
	endtask

	initial begin
		point_t p;
		int sweep;
		k_scale = longint'(cfl_scale(FB));
		courant_floor = QMAX;
		// origin, on-axis point, zero lapse, zero psi
		p = make_point(1'b0, 1'b0); p.radius_cyl = '0; p.height_z = '0; pending.push_back(p);
		p = make_point(1'b0, 1'b0); p.radius_cyl = '0; pending.push_back(p);
		p = make_point(1'b0, 1'b1); p.lapse = '0; pending.push_back(p);
		p = make_point(1'b0, 1'b1); p.lapse = '0; p.conformal_psi4 = '0; pending.push_back(p);
		p = make_point(1'b0, 1'b0); p.conformal_psi4 = '0; pending.push_back(p);
		// sweep ends with unit psi, a and b, zero c and lapse doubling 1/2 to 8
		for (int k = -1; k <= 3; k++) begin
			p = make_point(1'b0, 1'b1);
			p.conformal_psi4 = 48'(QONE); p.metric_a = 48'(QONE); p.metric_b = 48'(QONE);
			p.metric_c = '0; p.lapse = 48'(k < 0 ? (QONE >>> 1) : (QONE <<< k));
			pending.push_back(p);
		end
		// field extremes
		p = '1; pending.push_back(p);
		p = '0; pending.push_back(p);
		p = {{8{DMAX}}, 1'b1}; pending.push_back(p);
		p = {{8{DMIN}}, 1'b0}; pending.push_back(p);
		p = {DMAX, DMIN, DMAX, DMIN, DMAX, DMIN, DMAX, DMIN, 1'b1}; pending.push_back(p);
		p = {DMIN, DMAX, DMIN, DMAX, DMIN, DMAX, DMIN, DMAX, 1'b0}; pending.push_back(p);
		p = make_point(1'b0, 1'b0); p.lapse = DMIN; pending.push_back(p);
		p = make_point(1'b0, 1'b1); p.lapse = 48'd1; pending.push_back(p);
		for (int i = 0; i < 4; i++) pending.push_back(make_point(1'b1, 1'b1));
		sweep = 0;
		while (pending.size() < 20 + N_RANDOM) begin
			if (sweep == 0) sweep = $urandom_range(40, 1);
			sweep--;
			pending.push_back(make_point($urandom_range(9, 0) < 2, sweep == 0));
		end
		n_total = pending.size();
		drain_at = n_total / 2;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (n_sent == n_total);
		wait (expected_metrics.size() == 0);
		repeat (3000) @(posedge clk);
		$display("%0d points checked, %0d sweeps closed; codes 1-5 seen %0d %0d %0d %0d %0d",
			n_recv, n_last, code_seen[1], code_seen[2], code_seen[3], code_seen[4],
			code_seen[5]);
		if (n_errors == 0 && expected_metrics.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("TB_ERROR");
		end
		$finish;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (point_valid && !req_taken) begin
			end else begin
				req_taken = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
					point_valid <= 1'b0;
				end else if (n_sent == drain_at && !drained) begin
					if (expected_metrics.size() == 0) drained = 1'b1;
					point_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					point <= pending.pop_front();
					point_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(12, 0);
						gap_left = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(3000, 0);
					end
				end else begin
					point_valid <= 1'b0;
				end
			end
			stall_phase++;
			if (stall_phase >= 500) begin
				stall_phase = 0;
				stall_mode = $urandom_range(3, 0);
			end
			case (stall_mode)
				0: metric_stall <= 1'b0;
				1: metric_stall <= $urandom_range(9, 0) < 3;
				2: metric_stall <= $urandom_range(9, 0) < 8;
				default: metric_stall <= stall_phase[6];
			endcase
		end
	end

	always @(posedge clk) begin
		metric_t e;
		idle_cycles++;
		if (point_valid && !point_stall) begin
			expected_metrics.push_back(predict_metric(point));
			req_taken = 1'b1;
			n_sent++;
			idle_cycles = 0;
		end
		if (metric_valid && !metric_stall) begin
			idle_cycles = 0;
			if (expected_metrics.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("unexpected result %h", metric);
			end else begin
				e = expected_metrics.pop_front();
				check_field("sph_rr", e.sph_rr, metric.sph_rr);
				check_field("sph_thth", e.sph_thth, metric.sph_thth);
				check_field("sph_phph", e.sph_phph, metric.sph_phph);
				check_field("sph_rth", e.sph_rth, metric.sph_rth);
				check_field("inv_rr", e.inv_rr, metric.inv_rr);
				check_field("inv_thth", e.inv_thth, metric.inv_thth);
				check_field("inv_phph", e.inv_phph, metric.inv_phph);
				check_field("inv_rth", e.inv_rth, metric.inv_rth);
				check_field("speed_r", e.speed_r, metric.speed_r);
				check_field("speed_theta", e.speed_theta, metric.speed_theta);
				check_field("speed_phi", e.speed_phi, metric.speed_phi);
				check_field("cfl_code", 48'(e.cfl_code), 48'(metric.cfl_code));
				if (e.cfl_code != CFL_NONE) n_last++;
				code_seen[e.cfl_code]++;
			end
			n_recv++;
		end
		if (idle_cycles >= WD_LIMIT) begin
			$display("no progress for %0d cycles", idle_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

// ----- sim.f -----
rtl/mlsc_pkg.sv
rtl/mlsc_alu.sv
rtl/metric_light_speed_courant.sv
rtl/mlsc_chk.sv
tb/metric_light_speed_courant_tb.sv
